// ----- hw/rtl/bcdd_pkg.sv -----
`default_nettype none

package bcdd_pkg;

	// Geometry of the per-block state.
	localparam int NUM_BLOCKS = 64;
	localparam int MAX_DELAY  = 256;

	// Field and register widths.
	localparam int BLK_W     = 6;
	localparam int CON_W     = 16;
	localparam int RATIO_W   = 9;
	localparam int WEIGHT_W  = 16;
	localparam int DELAY_W   = 9;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DROP_RATIO     = 2'd0,
		CFG_EMA_WEIGHT     = 2'd1,
		CFG_BASELINE_DELAY = 2'd2
	} cfg_idx_t;

	// Stream payload widths, padded to whole bytes.
	localparam int IN_TDATA_W  = ((BLK_W + CON_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((BLK_W + 1 + 7) / 8) * 8;

	// Per-block counters and memory addressing.
	localparam int CNT_W   = $clog2(MAX_DELAY + 1);
	localparam int PTR_W   = $clog2(MAX_DELAY);
	localparam int ST_AW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
	localparam int RING_DEPTH = NUM_BLOCKS * MAX_DELAY;
	localparam int RING_AW = $clog2(RING_DEPTH);

	// Queue between the front and the back.
	localparam int Q_DEPTH = 4;
	localparam int QPTR_W  = $clog2(Q_DEPTH);
	localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

	// Bookkeeping kept for one block.
	typedef struct packed {
		logic             smoke;
		logic [CNT_W-1:0] cnt;
		logic [PTR_W-1:0] wp;
		logic [CON_W-1:0] ema;
	} blk_state_t;

	localparam int ST_W = $bits(blk_state_t);

	// One classified item on its way from the front to the back.
	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic [CON_W-1:0] contrast;
		logic             in_range;
		logic             check_onset;
		blk_state_t       st;
		logic [CON_W-1:0] base;
	} work_t;

	// Write-back of one item into the state and ring memories.
	typedef struct packed {
		logic               st_we;
		logic [ST_AW-1:0]   st_addr;
		blk_state_t         st_data;
		logic               ring_we;
		logic [RING_AW-1:0] ring_addr;
		logic [CON_W-1:0]   ring_data;
	} wb_t;

	// Block held by a stage, used to hold back a repeat of that block.
	typedef struct packed {
		logic             vld;
		logic [BLK_W-1:0] blk;
	} tag_t;

endpackage

`default_nettype wire

// ----- hw/rtl/block_contrast_drop_detector_top.sv -----
// Path: an item passes the front stages s1 and s2, the queue, the back stage and the output register.
// Throughput: one item per cycle while the blocks differ and neither the queue nor the output
// holds the flow; an item for a block that is still in flight waits until that block's state
// is written back (set by the read-modify-write loop through the state memory).
// Reset: arst_n clears the pipeline, the queue, the per-block valid bits (all blocks read as
// cleared) and loads the register reset values; the ring memory is not cleared.
`default_nettype none

module block_contrast_drop_detector_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// s_tdata: block_index [5:0], contrast [21:6], zero pad above
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [bcdd_pkg::IN_TDATA_W-1:0]   s_tdata,
	// m_tdata: block_number [5:0], smoke_mask [6], zero pad above
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [bcdd_pkg::OUT_TDATA_W-1:0]       m_tdata,
	input  wire logic                              cfg_wr_en,
	input  wire logic [bcdd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [bcdd_pkg::CFG_W-1:0]        cfg_data
);

	import bcdd_pkg::*;

	localparam logic [RATIO_W-1:0]  RATIO_RST  = RATIO_W'(179);
	localparam logic [WEIGHT_W-1:0] WEIGHT_RST = WEIGHT_W'(655);
	localparam logic [DELAY_W-1:0]  DELAY_RST  = DELAY_W'(150);

	logic [RATIO_W-1:0]  drop_ratio_q;
	logic [WEIGHT_W-1:0] ema_weight_q;
	logic [DELAY_W-1:0]  baseline_delay_q;
	logic [CNT_W-1:0]    delay;

	logic                in_blk_range;
	logic [BLK_W-1:0]    in_blk;
	logic [CON_W-1:0]    in_contrast;

	logic                st_re;
	logic [ST_AW-1:0]    st_raddr;
	blk_state_t          st_rdata;
	logic                ring_re;
	logic [RING_AW-1:0]  ring_raddr;
	logic [CON_W-1:0]    ring_rdata;
	logic                push;
	work_t               push_data;
	logic                pop;
	work_t               head;
	logic                q_empty;
	logic [QCNT_W-1:0]   q_count;
	tag_t [Q_DEPTH-1:0]  q_tags;
	tag_t                b1_tag;
	wb_t                 wb;
	logic                out_valid;
	logic [BLK_W-1:0]    out_blk;
	logic                out_mask;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_ratio_q     <= RATIO_RST;
			ema_weight_q     <= WEIGHT_RST;
			baseline_delay_q <= DELAY_RST;
		end else if (cfg_wr_en) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DROP_RATIO:     drop_ratio_q     <= cfg_data[RATIO_W-1:0];
				CFG_EMA_WEIGHT:     ema_weight_q     <= cfg_data[WEIGHT_W-1:0];
				CFG_BASELINE_DELAY: baseline_delay_q <= cfg_data[DELAY_W-1:0];
				default:            ;
			endcase
		end
	end

	// A delay of zero acts as one; larger values saturate at the ring size.
	always_comb begin
		in_blk_range = 1'b0;
		if (baseline_delay_q == '0) begin
			delay = CNT_W'(1);
		end else if (int'(baseline_delay_q) > MAX_DELAY) begin
			delay = CNT_W'(MAX_DELAY);
		end else begin
			delay = CNT_W'(baseline_delay_q);
		end
	end

	assign in_blk      = s_tdata[BLK_W-1:0];
	assign in_contrast = s_tdata[BLK_W +: CON_W];

	bcdd_ram #(
		.WIDTH(ST_W),
		.DEPTH(NUM_BLOCKS)
	) u_state_ram (
		.clk  (clk),
		.we   (wb.st_we),
		.waddr(wb.st_addr),
		.wdata(wb.st_data),
		.re   (st_re),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	bcdd_ram #(
		.WIDTH(CON_W),
		.DEPTH(RING_DEPTH)
	) u_ring_ram (
		.clk  (clk),
		.we   (wb.ring_we),
		.waddr(wb.ring_addr),
		.wdata(wb.ring_data),
		.re   (ring_re),
		.raddr(ring_raddr),
		.rdata(ring_rdata)
	);

	bcdd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_blk     (in_blk),
		.in_contrast(in_contrast),
		.delay      (delay),
		.q_count    (q_count),
		.q_tags     (q_tags),
		.b1_tag     (b1_tag),
		.wb         (wb),
		.st_re      (st_re),
		.st_raddr   (st_raddr),
		.st_rdata   (st_rdata),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.push       (push),
		.push_data  (push_data)
	);

	bcdd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.count    (q_count),
		.tags     (q_tags)
	);

	bcdd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.ratio    (drop_ratio_q),
		.weight   (ema_weight_q),
		.delay    (delay),
		.b1_tag   (b1_tag),
		.wb       (wb),
		.out_valid(out_valid),
		.out_ready(m_tready),
		.out_blk  (out_blk),
		.out_mask (out_mask)
	);

	assign m_tvalid = out_valid;
	assign m_tdata  = {{(OUT_TDATA_W - BLK_W - 1){in_blk_range}}, out_mask, out_blk};

	// A block's state row is never read on the edge at which it is written back.
	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		wb.st_we && st_re |-> wb.st_addr != st_raddr)
		else $error("state row read while its write-back is pending");

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_ram.sv -----
`default_nettype none

module bcdd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port; a read of the address
	// being written returns the old word.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_front.sv -----
`default_nettype none

module bcdd_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic [bcdd_pkg::BLK_W-1:0]     in_blk,
	input  wire logic [bcdd_pkg::CON_W-1:0]     in_contrast,
	input  wire logic [bcdd_pkg::CNT_W-1:0]     delay,
	input  wire logic [bcdd_pkg::QCNT_W-1:0]    q_count,
	input  wire bcdd_pkg::tag_t [bcdd_pkg::Q_DEPTH-1:0] q_tags,
	input  wire bcdd_pkg::tag_t                 b1_tag,
	input  wire bcdd_pkg::wb_t                  wb,
	output logic                                st_re,
	output logic [bcdd_pkg::ST_AW-1:0]          st_raddr,
	input  wire bcdd_pkg::blk_state_t           st_rdata,
	output logic                                ring_re,
	output logic [bcdd_pkg::RING_AW-1:0]        ring_raddr,
	input  wire logic [bcdd_pkg::CON_W-1:0]     ring_rdata,
	output logic                                push,
	output bcdd_pkg::work_t                     push_data
);

	import bcdd_pkg::*;

	localparam int POS_W = PTR_W + 2;

	logic [NUM_BLOCKS-1:0] vld_q;
	logic                  v_s1;
	logic [BLK_W-1:0]      blk_s1;
	logic [CON_W-1:0]      con_s1;
	logic                  v_s2;
	work_t                 work_s2;

	logic                  hit;
	logic [QCNT_W:0]       slots_used;
	logic                  accept;
	logic [ST_AW-1:0]      row_s1;
	logic                  in_range_s1;
	blk_state_t            st_s1;
	logic                  check_onset_s1;
	logic                  need_base_s1;
	logic [POS_W-1:0]      pos_sum;
	logic [PTR_W-1:0]      pos_s1;

	// Hold back a block that is still in flight anywhere up to its write-back,
	// and keep room in the queue for every item already in the front.
	always_comb begin
		hit = (v_s1 && blk_s1 == in_blk) || (v_s2 && work_s2.blk == in_blk) ||
			(b1_tag.vld && b1_tag.blk == in_blk);
		for (int i = 0; i < Q_DEPTH; i++) begin
			if (q_tags[i].vld && q_tags[i].blk == in_blk) begin
				hit = 1'b1;
			end
		end
	end

	assign slots_used = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(v_s1) + (QCNT_W + 1)'(v_s2);
	assign in_ready   = !hit && (slots_used < (QCNT_W + 1)'(Q_DEPTH));
	assign accept     = in_valid && in_ready;

	// The state row is read as the item is taken.
	assign st_re    = accept;
	assign st_raddr = ST_AW'(in_blk);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			blk_s1 <= in_blk;
			con_s1 <= in_contrast;
		end
	end

	// Blocks never written read as the cleared state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wb.st_we) begin
			vld_q[wb.st_addr] <= 1'b1;
		end
	end

	// Classify the item and locate the oldest ring entry of its block.
	always_comb begin
		row_s1         = ST_AW'(blk_s1);
		in_range_s1    = int'(blk_s1) < NUM_BLOCKS;
		st_s1          = (in_range_s1 && vld_q[row_s1]) ? st_rdata : '0;
		check_onset_s1 = !st_s1.smoke && (st_s1.cnt >= delay);
		need_base_s1   = in_range_s1 && (st_s1.smoke || check_onset_s1);
		pos_sum        = POS_W'(st_s1.wp) + POS_W'(MAX_DELAY) - POS_W'(st_s1.cnt);
		if (pos_sum >= POS_W'(MAX_DELAY)) begin
			pos_sum = pos_sum - POS_W'(MAX_DELAY);
		end
		pos_s1 = PTR_W'(pos_sum);
	end

	assign ring_re    = v_s1 && need_base_s1;
	assign ring_raddr = RING_AW'(row_s1) * RING_AW'(MAX_DELAY) + RING_AW'(pos_s1);

	always_ff @(posedge clk) begin
		if (v_s1) begin
			work_s2.blk         <= blk_s1;
			work_s2.contrast    <= con_s1;
			work_s2.in_range    <= in_range_s1;
			work_s2.check_onset <= check_onset_s1;
			work_s2.st          <= st_s1;
			work_s2.base        <= '0;
		end
	end

	// The ring word arrives with the item and both go into the queue.
	always_comb begin
		push_data      = work_s2;
		push_data.base = ring_rdata;
	end

	assign push = v_s2;

	// A ring read only ever targets a block that holds at least one entry.
	a_ring_read_written: assert property (@(posedge clk) disable iff (!arst_n)
		ring_re |-> st_s1.cnt != '0)
		else $error("ring read of a block with an empty history");

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_queue.sv -----
`default_nettype none

module bcdd_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	input  wire bcdd_pkg::work_t             push_data,
	input  wire logic                        pop,
	output bcdd_pkg::work_t                  head,
	output logic                             empty,
	output logic [bcdd_pkg::QCNT_W-1:0]      count,
	output bcdd_pkg::tag_t [bcdd_pkg::Q_DEPTH-1:0] tags
);

	import bcdd_pkg::*;

	work_t             mem_q [Q_DEPTH];
	logic [Q_DEPTH-1:0] occ_q;
	logic [Q_DEPTH-1:0] occ_d;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Slot occupancy after this cycle's pop and push.
	always_comb begin
		occ_d = occ_q;
		if (pop) begin
			occ_d[rd_ptr_q] = 1'b0;
		end
		if (push) begin
			occ_d[wr_ptr_q] = 1'b1;
		end
	end

	// Pointers, occupancy and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			occ_q    <= '0;
			count_q  <= '0;
		end else begin
			occ_q <= occ_d;
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

	// Every held item exposes its block so the front can hold back repeats.
	always_comb begin
		for (int i = 0; i < Q_DEPTH; i++) begin
			tags[i].vld = occ_q[i];
			tags[i].blk = mem_q[i].blk;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != QCNT_W'(Q_DEPTH))
		else $error("item pushed into a full queue");

	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == QCNT_W'($countones(occ_q)))
		else $error("queue fill count disagrees with slot occupancy");

endmodule

`default_nettype wire

// ----- hw/rtl/bcdd_back.sv -----
`default_nettype none

module bcdd_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bcdd_pkg::work_t               head,
	input  wire logic                          q_empty,
	output logic                               pop,
	input  wire logic [bcdd_pkg::RATIO_W-1:0]  ratio,
	input  wire logic [bcdd_pkg::WEIGHT_W-1:0] weight,
	input  wire logic [bcdd_pkg::CNT_W-1:0]    delay,
	output bcdd_pkg::tag_t                     b1_tag,
	output bcdd_pkg::wb_t                      wb,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [bcdd_pkg::BLK_W-1:0]         out_blk,
	output logic                               out_mask
);

	import bcdd_pkg::*;

	// Ratio is Q1.8, so one is 256; weight is Q0.16.
	localparam int FRAC_R     = RATIO_W - 1;
	localparam int RATIO_ONE  = 1 << FRAC_R;
	localparam int PROD_ON_W  = CON_W + RATIO_W;
	localparam int PROD_OFF_W = CON_W + RATIO_W + 1;
	localparam int EMA_W      = CON_W + WEIGHT_W + 2;
	localparam int EMA_HALF   = 1 << (WEIGHT_W - 1);

	logic                         adv;
	logic                         v_b1;
	work_t                        w_b1;
	logic [PROD_ON_W-1:0]         on_prod_b1;
	logic [PROD_OFF_W-1:0]        off_prod_b1;
	logic signed [EMA_W-1:0]      ema_prod_b1;
	logic                         out_valid_q;
	logic [BLK_W-1:0]             out_blk_q;
	logic                         out_mask_q;

	logic [RATIO_W:0]             off_factor;
	logic signed [CON_W:0]        diff;
	logic [PROD_ON_W-1:0]         c_on;
	logic [PROD_OFF_W-1:0]        c_off;
	logic                         new_smoke;
	logic                         mask;
	logic signed [EMA_W-1:0]      acc;
	logic [CON_W-1:0]             val;
	logic [CNT_W:0]               cnt_inc;
	logic [CNT_W-1:0]             new_cnt;
	logic [PTR_W-1:0]             new_wp;
	blk_state_t                   new_st;
	logic                         commit;

	// The whole back part moves when the output register is empty or its result is being taken.
	assign adv = !out_valid_q || out_ready;
	assign pop = adv && !q_empty;

	// Products for both thresholds and the EMA step, taken as the item leaves the queue.
	always_comb begin
		off_factor = {1'b0, ratio} + (RATIO_W + 1)'(RATIO_ONE);
		diff       = $signed({1'b0, head.contrast}) - $signed({1'b0, head.st.ema});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (adv) begin
			v_b1 <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w_b1        <= head;
			on_prod_b1  <= head.base * ratio;
			off_prod_b1 <= head.base * off_factor;
			ema_prod_b1 <= diff * $signed({1'b0, weight});
		end
	end

	// Smoke decision, EMA update and the new state row.
	always_comb begin
		c_on  = PROD_ON_W'(w_b1.contrast) << FRAC_R;
		c_off = PROD_OFF_W'(w_b1.contrast) << (FRAC_R + 1);
		if (w_b1.st.smoke) begin
			new_smoke = !(c_off >= off_prod_b1);
		end else if (w_b1.check_onset) begin
			new_smoke = c_on < on_prod_b1;
		end else begin
			new_smoke = 1'b0;
		end
		mask = new_smoke;

		acc = $signed({2'b00, w_b1.st.ema, {WEIGHT_W{1'b0}}}) + ema_prod_b1 +
			$signed(EMA_W'(EMA_HALF));
		// The first entry of an empty ring is the contrast itself.
		val = (w_b1.st.cnt == '0) ? w_b1.contrast : acc[WEIGHT_W +: CON_W];

		cnt_inc = (CNT_W + 1)'(w_b1.st.cnt) + 1'b1;
		new_cnt = (cnt_inc > (CNT_W + 1)'(delay)) ? delay : CNT_W'(cnt_inc);
		new_wp  = (w_b1.st.wp == PTR_W'(MAX_DELAY - 1)) ? '0 : w_b1.st.wp + 1'b1;

		if (new_smoke) begin
			new_st       = w_b1.st;
			new_st.smoke = 1'b1;
		end else begin
			new_st.smoke = 1'b0;
			new_st.cnt   = new_cnt;
			new_st.wp    = new_wp;
			new_st.ema   = val;
		end
	end

	// Write-back happens on the edge at which the item moves to the output.
	assign commit = adv && v_b1 && w_b1.in_range;

	always_comb begin
		wb.st_we     = commit;
		wb.st_addr   = ST_AW'(w_b1.blk);
		wb.st_data   = new_st;
		wb.ring_we   = commit && !new_smoke;
		wb.ring_addr = RING_AW'(ST_AW'(w_b1.blk)) * RING_AW'(MAX_DELAY) +
			RING_AW'(w_b1.st.wp);
		wb.ring_data = val;
	end

	assign b1_tag.vld = v_b1;
	assign b1_tag.blk = w_b1.blk;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_b1) begin
			out_blk_q  <= w_b1.blk;
			out_mask_q <= w_b1.in_range && mask;
		end
	end

	assign out_valid = out_valid_q;
	assign out_blk   = out_blk_q;
	assign out_mask  = out_mask_q;

endmodule

`default_nettype wire

// ----- dv/tb_block_contrast_drop_detector_top.sv -----
`default_nettype none

module tb_block_contrast_drop_detector_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bcdd_pkg::*;

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_e;

	// One row of the directed part: either an item or a register write.
	typedef struct packed {
		row_kind_e        kind;
		cfg_idx_t         idx;
		logic [CFG_W-1:0] value;
		logic [BLK_W-1:0] blk;
		bit               typed;
		bit               flag;
	} dir_row_t;

	// What one result item should carry.
	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic             mask;
	} flag_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_W-1:0]       cfg_data = '0;

	// steady and hold_req are shared between the sender and the receiver processes.
	logic        steady = 1'b0;
	logic        hold_req = 1'b0;
	logic        hold_done = 1'b0;
	int unsigned hold_left = 0;

	flag_t       awaited_flags[$];
	dir_row_t    dir_rows[$];
	int unsigned mismatches = 0;

	// Predictor copy of the registers and of the per-block state.
	int unsigned      cur_ratio = 179;
	int unsigned      cur_weight = 655;
	int unsigned      cur_delay = 150;
	bit               p_smoke [NUM_BLOCKS];
	int unsigned      p_count [NUM_BLOCKS];
	int unsigned      p_wptr [NUM_BLOCKS];
	logic [CON_W-1:0] p_ema [NUM_BLOCKS];
	logic [CON_W-1:0] p_ring [NUM_BLOCKS][MAX_DELAY];

	// Typical contrast level per block, steering the random contrast values.
	int unsigned lvl [NUM_BLOCKS];

	// Random phases: registers, length, size of the block pool, no-idle flag, pressure.
	int unsigned ph_ratio  [9] = '{179, 256, 511,     0,  200,   230,   180,  300,   150};
	int unsigned ph_weight [9] = '{16384, 65535, 0, 32768, 8000, 40000, 20000, 3000, 12000};
	int unsigned ph_delay  [9] = '{4, 1, 0, 3, 2, 6, 256, 511, 5};
	int unsigned ph_items  [9] = '{220, 180, 150, 150, 180, 220, 300, 100, 150};
	int unsigned ph_pool   [9] = '{8, 4, 6, 6, 64, 16, 1, 1, 12};
	bit          ph_steady [9] = '{0, 1, 0, 0, 0, 0, 0, 0, 0};
	bit          ph_hold   [9] = '{0, 0, 0, 1, 0, 0, 0, 0, 0};

	block_contrast_drop_detector_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Judge one block's contrast against its baseline and update the history.
	function automatic bit judge_block(input logic [BLK_W-1:0] blk, input logic [CON_W-1:0] con);
		int unsigned       held;
		int unsigned       pos;
		longint unsigned   base;
		longint unsigned   lcon;
		longint unsigned   lema;
		longint unsigned   acc;
		logic [CON_W-1:0]  val;
		bit                flag;
		held = (cur_delay == 0) ? 1 : ((cur_delay > MAX_DELAY) ? MAX_DELAY : cur_delay);
		lcon = con;
		flag = 1'b0;
		pos = (p_wptr[blk] + MAX_DELAY - p_count[blk]) % MAX_DELAY;

		// A smoky block clears once contrast climbs back near the baseline.
		if (p_smoke[blk]) begin
			base = p_ring[blk][pos];
			if (lcon * 512 >= base * (256 + cur_ratio))
				p_smoke[blk] = 1'b0;
			flag = p_smoke[blk];
		end else if (p_count[blk] >= held) begin
			base = p_ring[blk][pos];
			flag = (lcon * 256) < (base * cur_ratio);
			p_smoke[blk] = flag;
		end

		// Clear blocks extend their baseline history with a new average.
		if (!p_smoke[blk]) begin
			if (p_count[blk] == 0) begin
				val = con;
			end else begin
				lema = p_ema[blk];
				acc = lema * (65536 - cur_weight) + lcon * cur_weight + 32768;
				val = CON_W'(acc >> 16);
			end
			p_ring[blk][p_wptr[blk]] = val;
			p_wptr[blk] = (p_wptr[blk] + 1) % MAX_DELAY;
			p_ema[blk] = val;
			p_count[blk] = (p_count[blk] + 1 > held) ? held : p_count[blk] + 1;
		end
		return flag;
	endfunction

	// Random contrast, mostly near the block's level, with drops and jumps mixed in.
	function automatic logic [CON_W-1:0] pick_contrast(input int unsigned b);
		int unsigned roll;
		int unsigned span;
		int          v;
		roll = $urandom_range(99);
		span = lvl[b] / 16 + 2;
		if (roll < 55) begin
			v = int'(lvl[b]) - int'(span / 2) + int'($urandom_range(span));
		end else if (roll < 75) begin
			v = (lvl[b] * $urandom_range(255)) / 256;
		end else if (roll < 85) begin
			v = $urandom_range(65535);
		end else if (roll < 92) begin
			lvl[b] = $urandom_range(65535);
			v = lvl[b];
		end else begin
			v = lvl[b] + lvl[b] / 8;
		end
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return CON_W'(v);
	endfunction

	function automatic dir_row_t item_row(input logic [BLK_W-1:0] blk, input logic [CON_W-1:0] con,
			input bit typed, input bit flag);
		dir_row_t row;
		row.kind = ROW_ITEM;
		row.idx = CFG_DROP_RATIO;
		row.value = con;
		row.blk = blk;
		row.typed = typed;
		row.flag = flag;
		return row;
	endfunction

	function automatic dir_row_t reg_row(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		dir_row_t row;
		row = '0;
		row.kind = ROW_REG;
		row.idx = idx;
		row.value = value;
		return row;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(input dir_row_t row);
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	// Offer one item, wait for it to be taken, then record its expected result.
	task automatic send_item(input logic [BLK_W-1:0] blk, input logic [CON_W-1:0] con,
			input bit typed, input bit flag);
		flag_t want;
		bit    got;
		while (!steady && $urandom_range(99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'({con, blk});
		do @(posedge clk); while (!s_tready);
		got = judge_block(blk, con);
		want.blk = blk;
		want.mask = typed ? flag : got;
		awaited_flags.insert(awaited_flags.size(), want);
	endtask

	// Registers change only once the block has drained.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
		s_tvalid <= 1'b0;
		while (awaited_flags.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_DROP_RATIO:     cur_ratio = value & 16'h01FF;
			CFG_EMA_WEIGHT:     cur_weight = value;
			CFG_BASELINE_DELAY: cur_delay = value & 16'h01FF;
			default: ;
		endcase
	endtask

	// Receiver readiness, with one long hold-off to back the block up.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_left <= 300;
			hold_done <= 1'b1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= 28);
		end
	end

	// Compare each result item with the oldest expectation.
	always @(posedge clk) begin
		flag_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (awaited_flags.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: block %0d mask %0b", m_tdata[5:0], m_tdata[6]);
			end else begin
				want = awaited_flags[0];
				awaited_flags.delete(0);
				if (m_tdata[5:0] !== want.blk || m_tdata[6] !== want.mask) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected block %0d mask %0b, got block %0d mask %0b",
							want.blk, want.mask, m_tdata[5:0], m_tdata[6]);
				end
			end
		end
	end

	// Stimulus: directed rows, then random phases.
	initial begin
		dir_row_t    row;
		int unsigned pool_base;
		int unsigned blk;

		for (int i = 0; i < NUM_BLOCKS; i++)
			lvl[i] = $urandom_range(65535, 256);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Right after reset no ring is full, so nothing can turn smoky.
		add_row(item_row(6'd0, 16'h0000, 1, 0));
		add_row(item_row(6'd63, 16'hFFFF, 1, 0));
		add_row(item_row(6'd0, 16'hFFFF, 1, 0));
		add_row(item_row(6'd63, 16'h0000, 1, 0));
		add_row(item_row(6'd42, 16'hAAAA, 1, 0));
		add_row(item_row(6'd21, 16'h5555, 1, 0));
		// Delay zero acts as one; a full ratio turns any drop smoky.
		add_row(reg_row(CFG_BASELINE_DELAY, 16'd0));
		add_row(reg_row(CFG_DROP_RATIO, 16'd256));
		add_row(item_row(6'd5, 16'd1000, 1, 0));
		add_row(item_row(6'd5, 16'd999, 1, 1));
		add_row(item_row(6'd5, 16'd1000, 1, 0));
		// Block 0 holds more entries than the lowered delay.
		add_row(item_row(6'd0, 16'h0000, 0, 0));
		// Full weight and a ratio above one.
		add_row(reg_row(CFG_EMA_WEIGHT, 16'hFFFF));
		add_row(reg_row(CFG_DROP_RATIO, 16'd511));
		add_row(item_row(6'd7, 16'h0100, 1, 0));
		add_row(item_row(6'd7, 16'h00FF, 1, 1));
		add_row(item_row(6'd7, 16'hFFFF, 1, 0));
		// Ratio zero never turns a block smoky.
		add_row(reg_row(CFG_DROP_RATIO, 16'd0));
		add_row(item_row(6'd7, 16'h0000, 1, 0));
		// An oversized delay saturates; zero weight freezes the average.
		add_row(reg_row(CFG_BASELINE_DELAY, 16'd511));
		add_row(item_row(6'd63, 16'h8000, 0, 0));
		add_row(reg_row(CFG_EMA_WEIGHT, 16'd0));
		add_row(item_row(6'd0, 16'h1234, 0, 0));

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.kind == ROW_REG)
				write_reg(row.idx, row.value);
			else
				send_item(row.blk, row.value, row.typed, row.flag);
		end

		// Random phases over a pool of blocks, so rings fill and drops show up.
		for (int p = 0; p < 9; p++) begin
			write_reg(CFG_DROP_RATIO, CFG_W'(ph_ratio[p]));
			write_reg(CFG_EMA_WEIGHT, CFG_W'(ph_weight[p]));
			write_reg(CFG_BASELINE_DELAY, CFG_W'(ph_delay[p]));
			steady <= ph_steady[p];
			if (ph_hold[p])
				hold_req <= 1'b1;
			pool_base = $urandom_range(NUM_BLOCKS - 1);
			for (int n = 0; n < ph_items[p]; n++) begin
				blk = (pool_base + $urandom_range(ph_pool[p] - 1)) % NUM_BLOCKS;
				send_item(BLK_W'(blk), pick_contrast(blk), 0, 0);
			end
		end

		// Drain and let the pipeline settle before the verdict.
		s_tvalid <= 1'b0;
		while (awaited_flags.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && awaited_flags.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
